[design/pdpt_pkg.sv]
// Package: shared types and codes for the pixel defect persistence tracker.
`timescale 1ns / 1ps
package pdpt_pkg;

    localparam logic [1:0] MODE_CAND  = 2'd0;
    localparam logic [1:0] MODE_SWEEP = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [1:0] ST_REPORT  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_SWEPT   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [15:0] confidence;
        logic [19:0] frame_idx;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] defect_x;
        logic [11:0] defect_y;
        logic [15:0] peak_confidence;
        logic [19:0] first_frame;
        logic [19:0] final_frame;
        logic [15:0] appearances;
        logic        last;
    } t_out_item;

endpackage

[design/pdpt_fifo.sv]
// Short queue of item beats between the front and back parts.
`timescale 1ns / 1ps
module pdpt_fifo
    import pdpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_in_item o_data
);
    // two-entry queue
    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, (i_push && !o_full)} - {1'b0, (i_pop && !o_empty)};
        end
    end
endmodule

[design/pdpt_front.sv]
// Front part: accepts item beats, drops ignored mode codes, feeds the queue.
`timescale 1ns / 1ps
module pdpt_front
    import pdpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_item,
    output logic     full,
    output logic     o_q_push,
    output t_in_item o_q_data,
    input  logic     i_q_full
);
    // register slice; mode three is classified as no-op and dropped here
    logic     r_vld;
    t_in_item r_item;
    logic     w_take;

    assign o_q_push = r_vld;
    assign o_q_data = r_item;
    assign full     = r_vld && i_q_full;
    assign w_take   = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_vld  <= (i_item.mode != MODE_NOP);
                r_item <= i_item;
            end else if (r_vld && !i_q_full) begin
                r_vld <= 1'b0;
            end
        end
    end
endmodule

[design/pdpt_back.sv]
// Back part: holds the table, runs candidate updates, sweeps and flushes.
`timescale 1ns / 1ps
module pdpt_back
    import pdpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_min_pers,
    input  logic        i_q_empty,
    input  t_in_item    i_q_data,
    output logic        o_q_pop,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_res
);
    localparam int IW = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state       r_state;
    logic [IW-1:0] r_idx;
    t_in_item     r_cmd;
    logic         r_ovld;
    t_out_item    r_out;
    logic [TABLE_ENTRIES-1:0] r_valid, r_seen;
    logic [11:0]  r_x    [TABLE_ENTRIES];
    logic [11:0]  r_y    [TABLE_ENTRIES];
    logic [15:0]  r_peak [TABLE_ENTRIES];
    logic [19:0]  r_start[TABLE_ENTRIES];
    logic [15:0]  r_cnt  [TABLE_ENTRIES];

    // associative match and free-slot search
    logic [TABLE_ENTRIES-1:0] w_hit;
    logic          w_found, w_free_ok;
    logic [IW-1:0] w_hidx, w_fidx;
    always_comb begin
        w_found = 1'b0; w_hidx = '0; w_free_ok = 1'b0; w_fidx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            w_hit[i] = r_valid[i] && r_x[i] == i_q_data.pix_x && r_y[i] == i_q_data.pix_y;
            if (w_hit[i]) begin w_found = 1'b1; w_hidx = IW'(i); end
            if (!r_valid[i]) begin w_free_ok = 1'b1; w_fidx = IW'(i); end
        end
    end

    // next qualifying slot at or after r_idx, for sweep or flush
    logic          w_nq;
    logic [IW-1:0] w_nidx;
    always_comb begin
        w_nq = 1'b0; w_nidx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (IW'(i) >= r_idx && r_valid[i] && r_cnt[i] >= i_min_pers
                && (r_cmd.mode == MODE_FLUSH || !r_seen[i])) begin
                w_nq = 1'b1; w_nidx = IW'(i);
            end
        end
    end
    // does another qualifying slot lie beyond w_nidx (flush last flag)
    logic w_more;
    always_comb begin
        w_more = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (IW'(i) > w_nidx && r_valid[i] && r_cnt[i] >= i_min_pers) w_more = 1'b1;
    end

    logic w_oslot;
    assign empty   = !r_ovld;
    assign w_oslot = !r_ovld || pop;
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty && w_oslot;

    // a result beat is loaded into the output register this cycle
    logic w_load;
    assign w_load = (o_q_pop && i_q_data.mode == MODE_CAND && !w_found && !w_free_ok)
                    || (r_state == S_SCAN && w_oslot && w_nq)
                    || (r_state == S_DONE && w_oslot && r_cmd.mode == MODE_SWEEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_valid <= '0;
            r_seen  <= '0;
            r_idx   <= '0;
        end else begin
            if (w_load) r_ovld <= 1'b1;
            else if (pop) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_cmd <= i_q_data;
                        r_idx <= '0;
                        if (i_q_data.mode == MODE_CAND) begin
                            if (w_found) begin
                                if (r_cnt[w_hidx] != 16'hFFFF)
                                    r_cnt[w_hidx] <= r_cnt[w_hidx] + 16'd1;
                                if (i_q_data.confidence > r_peak[w_hidx])
                                    r_peak[w_hidx] <= i_q_data.confidence;
                                r_seen[w_hidx] <= 1'b1;
                            end else if (w_free_ok) begin
                                r_valid[w_fidx] <= 1'b1;
                                r_seen[w_fidx]  <= 1'b1;
                                r_x[w_fidx]     <= i_q_data.pix_x;
                                r_y[w_fidx]     <= i_q_data.pix_y;
                                r_peak[w_fidx]  <= i_q_data.confidence;
                                r_start[w_fidx] <= i_q_data.frame_idx;
                                r_cnt[w_fidx]   <= 16'd1;
                            end else begin
                                r_out <= '{status: ST_DROPPED, last: 1'b1, default: '0};
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_oslot) begin
                        if (w_nq) begin
                            r_out.status          <= ST_REPORT;
                            r_out.defect_x        <= r_x[w_nidx];
                            r_out.defect_y        <= r_y[w_nidx];
                            r_out.peak_confidence <= r_peak[w_nidx];
                            r_out.first_frame     <= r_start[w_nidx];
                            r_out.appearances     <= r_cnt[w_nidx];
                            r_out.final_frame     <= (r_cmd.mode == MODE_FLUSH) ?
                                r_start[w_nidx] + {4'd0, r_cnt[w_nidx]} - 20'd1 :
                                r_cmd.frame_idx - 20'd1;
                            r_out.last <= (r_cmd.mode == MODE_FLUSH) && !w_more;
                            r_idx      <= w_nidx + IW'(1);
                            if (w_nidx == IW'(TABLE_ENTRIES - 1)) r_state <= S_DONE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_oslot) begin
                        if (r_cmd.mode == MODE_SWEEP) begin
                            r_valid <= r_valid & r_seen;
                            r_out   <= '{status: ST_SWEPT, last: 1'b1, default: '0};
                        end else begin
                            r_valid <= '0;
                        end
                        r_seen  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res = r_out;
endmodule

[design/pixel_defect_persistence_tracker.sv]
// Top level: pixel defect persistence tracker.
// Use: push candidate, end-of-frame and flush beats on the input queue
// port (push/full); take result beats from the output queue port
// (empty/pop), oldest first, each carrying a last flag.
// The user is to write the persistence threshold through i_cfg_we/i_cfg_data
// only while idle; the block itself does not enforce this.
// Path: an input beat passes the front slice and the two-entry queue to the
// back part. A dropped candidate's beat is loaded as it is popped; a sweep or
// flush loads its reports from the scan, and a sweep then its closing beat.
// Throughput: candidates stream at one per cycle while no sweep or flush holds
// the back part and the result register can take a beat, since the front slice
// and queue are pipelined and the back part matches all slots at once.
// A sweep or flush holds the back part while it takes the beat, scans with one
// report beat per cycle while the receiver keeps up, ends the scan and closes.
// Reset empties the table, restores the threshold to five and drops
// queued beats. When the receiver stalls the result register holds,
// the back part stops, the queue fills and full rises.
`timescale 1ns / 1ps
module pixel_defect_persistence_tracker
    import pdpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_item    i_item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_min_pers;
    logic        w_qpush, w_qfull, w_qpop, w_qempty;
    t_in_item    w_qin, w_qout;

    // hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_pers <= 16'd5;
        else if (i_cfg_we) r_min_pers <= i_cfg_data;
    end

    pdpt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item), .full(full),
        .o_q_push(w_qpush), .o_q_data(w_qin), .i_q_full(w_qfull)
    );

    pdpt_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_qpush), .i_data(w_qin),
        .o_full(w_qfull), .i_pop(w_qpop), .o_empty(w_qempty), .o_data(w_qout)
    );

    pdpt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_min_pers(r_min_pers),
        .i_q_empty(w_qempty), .i_q_data(w_qout), .o_q_pop(w_qpop),
        .empty(empty), .pop(pop), .o_res(o_result)
    );
endmodule

[design/pdpt_checker.sv]
// Checker: port-level properties of the tracker, bound to the top level.
`timescale 1ns / 1ps
module pdpt_checker
    import pdpt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result))) else $error("result not held");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.status == ST_REPORT || o_result.status == ST_DROPPED
                    || o_result.status == ST_SWEPT)) else $error("bad status");
    a_droplast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_REPORT) |-> o_result.last)
        else $error("drop or sweep without last");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty) else $error("not empty");
endmodule

bind pixel_defect_persistence_tracker pdpt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_result(o_result)
);

[tb/sv/tb_top.sv]
// Testbench for the pixel defect persistence tracker: directed table then random frames.
`timescale 1ns / 1ps
module tb_top;
    import pdpt_pkg::*;

    localparam int SLOTS = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    t_in_item    i_item = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_result;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    pixel_defect_persistence_tracker #(.TABLE_ENTRIES(SLOTS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item),
        .full(full), .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // Shadow of the defect table, kept in step with accepted beats
    logic        sh_valid [SLOTS];
    logic        sh_seen  [SLOTS];
    logic [11:0] sh_x     [SLOTS];
    logic [11:0] sh_y     [SLOTS];
    logic [15:0] sh_peak  [SLOTS];
    logic [19:0] sh_start [SLOTS];
    logic [15:0] sh_count [SLOTS];
    logic [15:0] sh_min_persist;

    t_out_item   pending_reports[$];
    bit          failed = 1'b0;
    bit          idle_enable = 1'b1;
    int          quiet_cycles = 0;

    function automatic t_out_item make_report(logic [1:0] st, int s, logic [19:0] fin);
        t_out_item r;
        r = '0;
        r.status = st;
        if (s >= 0) begin
            r.defect_x = sh_x[s];
            r.defect_y = sh_y[s];
            r.peak_confidence = sh_peak[s];
            r.first_frame = sh_start[s];
            r.final_frame = fin;
            r.appearances = sh_count[s];
        end
        return r;
    endfunction

    // Append one expected result beat
    task automatic expect_beat(input t_out_item r);
        pending_reports.insert(pending_reports.size(), r);
    endtask

    // Work out the result beats an accepted input beat causes and advance the shadow
    task automatic track_beat(input t_in_item it);
        int free_slot;
        int first_new;
        t_out_item r;
        free_slot = -1;
        first_new = pending_reports.size();
        case (it.mode)
            MODE_CAND: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (sh_valid[s] && sh_x[s] == it.pix_x && sh_y[s] == it.pix_y) begin
                        if (sh_count[s] != 16'hFFFF) sh_count[s]++;
                        if (it.confidence > sh_peak[s]) sh_peak[s] = it.confidence;
                        sh_seen[s] = 1'b1;
                        return;
                    end
                    if (!sh_valid[s] && free_slot < 0) free_slot = s;
                end
                if (free_slot < 0) begin
                    r = make_report(ST_DROPPED, -1, '0);
                    r.last = 1'b1;
                    expect_beat(r);
                end else begin
                    sh_valid[free_slot] = 1'b1;
                    sh_seen[free_slot]  = 1'b1;
                    sh_x[free_slot]     = it.pix_x;
                    sh_y[free_slot]     = it.pix_y;
                    sh_peak[free_slot]  = it.confidence;
                    sh_start[free_slot] = it.frame_idx;
                    sh_count[free_slot] = 16'd1;
                end
            end
            MODE_SWEEP: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!sh_valid[s]) continue;
                    if (sh_seen[s]) begin
                        sh_seen[s] = 1'b0;
                        continue;
                    end
                    if (sh_count[s] >= sh_min_persist)
                        expect_beat(make_report(ST_REPORT, s, it.frame_idx - 20'd1));
                    sh_valid[s] = 1'b0;
                end
                r = make_report(ST_SWEPT, -1, '0);
                r.last = 1'b1;
                expect_beat(r);
            end
            MODE_FLUSH: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (sh_valid[s] && sh_count[s] >= sh_min_persist)
                        expect_beat(make_report(ST_REPORT, s,
                            sh_start[s] + 20'(sh_count[s]) - 20'd1));
                    sh_valid[s] = 1'b0;
                    sh_seen[s]  = 1'b0;
                end
                if (pending_reports.size() > first_new)
                    pending_reports[pending_reports.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Result side: pop at random, compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, o_result);
                    failed = 1'b1;
                end else begin
                    t_out_item want;
                    want = pending_reports.pop_front();
                    if (o_result !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, o_result);
                        failed = 1'b1;
                    end
                end
            end
            pop <= !idle_enable || ($urandom_range(99) >= 32);
        end
    end

    // Watchdog: count cycles in which neither side accepts a beat
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Hold push high until the beat is taken; idle at random between beats.
    // Push stays high after the last beat until drain_and_settle drops it.
    task automatic send_beat(input t_in_item it);
        while (idle_enable && $urandom_range(99) < 32) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        track_beat(it);
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        // cover beats still in flight that cause no result
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_min_persist(input logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sh_min_persist = v;
    endtask

    function automatic t_in_item beat(logic [1:0] m, logic [11:0] x, logic [11:0] y,
                                      logic [15:0] c, logic [19:0] f);
        t_in_item it;
        it.mode = m; it.pix_x = x; it.pix_y = y; it.confidence = c; it.frame_idx = f;
        return it;
    endfunction

    // Directed rows go through the predictor; the report of the second sweep at frame zero is also typed in
    t_in_item   directed_rows[$];
    t_out_item  typed_result;

    initial begin
        logic [19:0] frame_no;
        int          n_px;
        logic [11:0] px_pool_x [8];
        logic [11:0] px_pool_y [8];

        for (int s = 0; s < SLOTS; s++) begin
            sh_valid[s] = 1'b0; sh_seen[s] = 1'b0;
            sh_x[s] = '0; sh_y[s] = '0; sh_peak[s] = '0; sh_start[s] = '0; sh_count[s] = '0;
        end
        sh_min_persist = 16'd5;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: reset threshold; extremes, repeats, mode three and a first sweep
        directed_rows = '{
            beat(MODE_CAND, 12'hFFF, 12'hFFF, 16'hFFFF, 20'hFFFFF),
            beat(MODE_CAND, 12'h000, 12'h000, 16'h0000, 20'h00000),
            beat(MODE_CAND, 12'hFFF, 12'hFFF, 16'h0001, 20'hFFFFF),
            beat(MODE_CAND, 12'hFFF, 12'hFFF, 16'h0002, 20'hFFFFF),
            beat(MODE_CAND, 12'hFFF, 12'hFFF, 16'h0003, 20'hFFFFF),
            beat(MODE_CAND, 12'hFFF, 12'hFFF, 16'h0004, 20'hFFFFF),
            beat(MODE_NOP,  12'hABC, 12'h543, 16'h1234, 20'h5A5A5),
            beat(MODE_SWEEP, 12'h000, 12'h000, 16'h0000, 20'h00000)
        };
        foreach (directed_rows[k]) send_beat(directed_rows[k]);
        drain_and_settle();

        // Second sweep at frame zero closes the big entry: final frame wraps
        typed_result = '{status: ST_REPORT, defect_x: 12'hFFF, defect_y: 12'hFFF,
                         peak_confidence: 16'hFFFF, first_frame: 20'hFFFFF,
                         final_frame: 20'hFFFFF, appearances: 16'd5, last: 1'b0};
        send_beat(beat(MODE_SWEEP, 12'h000, 12'h000, 16'h0000, 20'h00000));
        if (pending_reports.size() != 2 || pending_reports[0] !== typed_result) begin
            $display("%0t: mismatch expected %h actual %h", $time, typed_result,
                     pending_reports[0]);
            failed = 1'b1;
        end
        drain_and_settle();
        if (sh_valid[0]) begin
            $display("%0t: shadow table out of step", $time);
            failed = 1'b1;
        end

        // Phase two: threshold zero, fill the table past capacity, then a sweep and two flushes
        write_min_persist(16'd0);
        for (int k = 0; k < SLOTS + 2; k++)
            send_beat(beat(MODE_CAND, 12'(k * 97), 12'(4095 - k), 16'(k * 1000), 20'(k)));
        send_beat(beat(MODE_SWEEP, '0, '0, '0, 20'd40));
        send_beat(beat(MODE_FLUSH, '0, '0, '0, 20'd41));
        send_beat(beat(MODE_FLUSH, '0, '0, '0, 20'd42));
        drain_and_settle();

        // Phase three: threshold at its top, repeats on a few pixels; flush reports nothing
        write_min_persist(16'hFFFF);
        for (int k = 0; k < 60; k++)
            send_beat(beat(MODE_CAND, 12'(k % 3), 12'h456, 16'(k * 331), 20'h00010));
        send_beat(beat(MODE_FLUSH, '0, '0, '0, '0));
        drain_and_settle();

        // Random part: well-formed frames of recurring pixels, with noise and odd modes
        for (int cfg = 0; cfg < 3; cfg++) begin
            write_min_persist(cfg == 0 ? 16'd1 : cfg == 1 ? 16'd3 : 16'($urandom_range(2, 6)));
            for (int p = 0; p < 8; p++) begin
                px_pool_x[p] = 12'($urandom);
                px_pool_y[p] = 12'($urandom);
            end
            frame_no = 20'($urandom);
            idle_enable = (cfg != 1);
            for (int f = 0; f < 12; f++) begin
                n_px = $urandom_range(1, 6);
                for (int k = 0; k < n_px; k++) begin
                    if ($urandom_range(9) < 7) begin
                        int p;
                        p = $urandom_range(7);
                        send_beat(beat(MODE_CAND, px_pool_x[p], px_pool_y[p],
                                       16'($urandom), frame_no));
                    end else
                        send_beat(beat(2'($urandom), 12'($urandom), 12'($urandom),
                                       16'($urandom), 20'($urandom)));
                end
                send_beat(beat(MODE_SWEEP, 12'($urandom), 12'($urandom),
                               16'($urandom), frame_no + 20'd1));
                frame_no = frame_no + 20'd1;
            end
            send_beat(beat(MODE_FLUSH, 12'($urandom), 12'($urandom),
                           16'($urandom), 20'($urandom)));
            drain_and_settle();
        end

        if (!failed && pending_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
